// ===== rtl/srr_pkg.sv =====
package srr_pkg;

    localparam int CoordW  = 12;
    localparam int DimW    = 13;
    localparam int ColorW  = 32;
    localparam int OffsetW = 12;
    localparam int CfgIdxW = 3;

    localparam logic [DimW-1:0] MaxDimension = 13'd4096;

    localparam logic [CfgIdxW-1:0] REG_REGION_LEFT     = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_REGION_TOP      = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_REGION_COLUMNS  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_REGION_ROWS     = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_SURFACE_COLUMNS = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_SURFACE_ROWS    = 3'd5;

    typedef enum logic [1:0] {
        MODE_SCROLL = 2'd0,
        MODE_RESET  = 2'd1,
        MODE_MAP    = 2'd2,
        MODE_FILL   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_POINT    = 2'd0,
        KIND_FILL     = 2'd1,
        KIND_FALLBACK = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        MOD_IDLE,
        MOD_SETTLE,
        MOD_RUN
    } t_mod_state;

    // Surface size and scroll region after clipping to the surface.
    typedef struct packed {
        logic [DimW-1:0]   surf_cols;
        logic [DimW-1:0]   surf_rows;
        logic              valid;
        logic [CoordW-1:0] left;
        logic [CoordW-1:0] top;
        logic [DimW-1:0]   right;
        logic [DimW-1:0]   bottom;
        logic [DimW-1:0]   rows;
    } t_geom;

    // All results of one item; the second result differs only in row and height.
    typedef struct packed {
        t_kind             kind;
        logic [CoordW-1:0] x;
        logic [DimW-1:0]   w;
        logic [ColorW-1:0] color;
        logic              in_surface;
        logic              in_region;
        logic [CoordW-1:0] y0;
        logic [DimW-1:0]   h0;
        logic [CoordW-1:0] y1;
        logic [DimW-1:0]   h1;
        logic              two;
    } t_bundle;

    typedef struct packed {
        t_kind             kind;
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic [DimW-1:0]   w;
        logic [DimW-1:0]   h;
        logic [ColorW-1:0] color;
        logic              in_surface;
        logic              in_region;
        logic              last;
    } t_result;

    function automatic logic [DimW-1:0] sat_dim(input logic [DimW-1:0] v);
        return (v > MaxDimension) ? MaxDimension : v;
    endfunction

endpackage

// ===== rtl/scroll_region_row_remapper.sv =====
// An accepted item is held in the input register, then written to the result queue,
// whose head drives the output. Throughput: one item per cycle while the queue has
// space and no offset reduction runs; a fill that wraps gives two results in turn.
// After the last configuration write, the input is held off while the row offset is
// reduced modulo the new region height, one quotient bit per cycle.
// Synchronous active-low reset clears the configuration registers and the row offset.
module scroll_region_row_remapper (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [12:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // distance[12:0], pos_x[24:13], pos_y[36:25], span_w[49:37], span_h[62:50],
    // fill_color[94:63], zero[95]
    input  logic [95:0]  s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_x[11:0], out_y[23:12], out_w[36:24], out_h[49:37], out_color[81:50],
    // inside_surface[82], inside_region[83], zero[87:84]
    output logic [87:0]  m_axis_tdata,
    // kind[1:0]
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);
    import srr_pkg::*;

    t_geom              geom;
    logic               mod_busy;
    logic [OffsetW-1:0] mod_rem;
    logic               mod_load;
    logic [OffsetW-1:0] mod_load_val;
    logic               q_space;
    logic               q_push;
    t_bundle            q_bundle;
    t_result            q_result;

    logic               r_in_valid;
    t_mode              r_in_mode;
    logic [DimW-1:0]    r_in_dist;
    logic [CoordW-1:0]  r_in_x;
    logic [CoordW-1:0]  r_in_y;
    logic [DimW-1:0]    r_in_w;
    logic [DimW-1:0]    r_in_h;
    logic [ColorW-1:0]  r_in_color;
    logic [OffsetW-1:0] r_row_offset;

    logic               accept;
    logic               advance;

    logic [DimW-1:0]    rot_sum;
    logic [DimW-1:0]    rot_wrap;
    logic [CoordW-1:0]  rot_y;
    logic               is_s;
    logic               is_r;
    logic [DimW:0]      fx1_raw;
    logic [DimW:0]      fy1_raw;
    logic [DimW-1:0]    fx1;
    logic [DimW-1:0]    fy1;
    logic               fill_any;
    logic [DimW-1:0]    fw;
    logic [DimW-1:0]    fh;
    logic [DimW-1:0]    ox0, ox1, oy0, oy1;
    logic               overlap;
    logic               contained;
    logic [DimW:0]      rot_end;
    logic [DimW-1:0]    first_h;
    logic [DimW-1:0]    scroll_sum;
    logic [OffsetW-1:0] scroll_next;
    logic               scroll_apply;

    srr_cfg_geom u_cfg_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_geom      (geom)
    );

    srr_mod_unit u_mod_unit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cfg_we),
        .i_dividend (r_row_offset),
        .i_divisor  (geom.rows),
        .i_load     (mod_load),
        .i_load_val (mod_load_val),
        .o_busy     (mod_busy),
        .o_rem      (mod_rem)
    );

    srr_result_queue u_result_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_bundle (q_bundle),
        .o_space  (q_space),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (q_result)
    );

    assign advance       = r_in_valid && q_space;
    assign s_axis_tready = !mod_busy && (!r_in_valid || q_space);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_mode  <= t_mode'(s_axis_tuser);
            r_in_dist  <= s_axis_tdata[12:0];
            r_in_x     <= s_axis_tdata[24:13];
            r_in_y     <= s_axis_tdata[36:25];
            r_in_w     <= s_axis_tdata[49:37];
            r_in_h     <= s_axis_tdata[62:50];
            r_in_color <= s_axis_tdata[94:63];
        end
    end

    // Row rotation: both terms are below the region height, so one subtract wraps it.
    always_comb begin
        rot_sum  = {1'b0, r_in_y - geom.top} + {1'b0, mod_rem};
        rot_wrap = (rot_sum >= geom.rows) ? (rot_sum - geom.rows) : rot_sum;
        rot_y    = geom.top + rot_wrap[CoordW-1:0];
    end

    always_comb begin
        is_s = ({1'b0, r_in_x} < geom.surf_cols) && ({1'b0, r_in_y} < geom.surf_rows);
        is_r = geom.valid && (r_in_x >= geom.left) && ({1'b0, r_in_x} < geom.right)
               && (r_in_y >= geom.top) && ({1'b0, r_in_y} < geom.bottom);
    end

    // Fill clipped to the surface, then compared against the region.
    always_comb begin
        fx1_raw  = {2'b00, r_in_x} + {1'b0, r_in_w};
        fy1_raw  = {2'b00, r_in_y} + {1'b0, r_in_h};
        fx1      = (fx1_raw < {1'b0, geom.surf_cols}) ? fx1_raw[DimW-1:0] : geom.surf_cols;
        fy1      = (fy1_raw < {1'b0, geom.surf_rows}) ? fy1_raw[DimW-1:0] : geom.surf_rows;
        fill_any = (fx1 > {1'b0, r_in_x}) && (fy1 > {1'b0, r_in_y});
        fw       = fx1 - {1'b0, r_in_x};
        fh       = fy1 - {1'b0, r_in_y};

        ox0 = (r_in_x > geom.left) ? {1'b0, r_in_x} : {1'b0, geom.left};
        oy0 = (r_in_y > geom.top) ? {1'b0, r_in_y} : {1'b0, geom.top};
        ox1 = (fx1 < geom.right) ? fx1 : geom.right;
        oy1 = (fy1 < geom.bottom) ? fy1 : geom.bottom;
        overlap   = geom.valid && (ox1 > ox0) && (oy1 > oy0);
        contained = geom.valid && (r_in_x >= geom.left) && (fx1 <= geom.right)
                    && (r_in_y >= geom.top) && (fy1 <= geom.bottom);

        rot_end = {2'b00, rot_y} + {1'b0, fh};
        first_h = geom.bottom - {1'b0, rot_y};
    end

    always_comb begin
        scroll_apply = geom.valid && (r_in_dist != '0);
        scroll_sum   = {1'b0, mod_rem} + r_in_dist;
        if (r_in_dist >= geom.rows) begin
            scroll_next = '0;
        end else if (scroll_sum >= geom.rows) begin
            scroll_next = OffsetW'(scroll_sum - geom.rows);
        end else begin
            scroll_next = scroll_sum[OffsetW-1:0];
        end
    end

    always_comb begin
        q_push              = 1'b0;
        mod_load            = 1'b0;
        mod_load_val        = '0;
        q_bundle.kind       = KIND_FILL;
        q_bundle.x          = r_in_x;
        q_bundle.w          = fw;
        q_bundle.color      = r_in_color;
        q_bundle.in_surface = 1'b0;
        q_bundle.in_region  = 1'b0;
        q_bundle.y0         = r_in_y;
        q_bundle.h0         = fh;
        q_bundle.y1         = geom.top;
        q_bundle.h1         = fh - first_h;
        q_bundle.two        = 1'b0;

        unique case (r_in_mode)
            MODE_SCROLL: begin
                mod_load     = advance && scroll_apply;
                mod_load_val = scroll_next;
            end
            MODE_RESET: begin
                mod_load     = advance;
                mod_load_val = '0;
            end
            MODE_MAP: begin
                q_push              = advance;
                q_bundle.kind       = KIND_POINT;
                q_bundle.w          = '0;
                q_bundle.h0         = '0;
                q_bundle.color      = '0;
                q_bundle.in_surface = is_s;
                q_bundle.in_region  = is_r;
                q_bundle.y0         = is_r ? rot_y : r_in_y;
            end
            MODE_FILL: begin
                q_push = advance && fill_any;
                if (r_row_offset != '0 && contained) begin
                    q_bundle.y0 = rot_y;
                    if (rot_end > {1'b0, geom.bottom}) begin
                        q_bundle.h0  = first_h;
                        q_bundle.two = 1'b1;
                    end
                end else if (r_row_offset != '0 && overlap) begin
                    q_bundle.kind = KIND_FALLBACK;
                end
            end
            default: begin
            end
        endcase
    end

    // The raw offset is kept for the zero test; the reduced copy lives in the mod unit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_offset <= '0;
        end else if (mod_load) begin
            r_row_offset <= mod_load_val;
        end
    end

    assign m_axis_tdata = {4'b0000, q_result.in_region, q_result.in_surface, q_result.color,
                           q_result.h, q_result.w, q_result.y, q_result.x};
    assign m_axis_tuser = q_result.kind;
    assign m_axis_tlast = q_result.last;

    a_hold_off_while_reducing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_busy |-> !s_axis_tready)
        else $error("item accepted while the row offset is being reduced");

    a_reset_clears_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_mode == MODE_RESET) |=> (r_row_offset == '0 && mod_rem == '0))
        else $error("reset command left a nonzero row offset");

endmodule

// ===== rtl/srr_cfg_geom.sv =====
module srr_cfg_geom (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [srr_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [srr_pkg::DimW-1:0]     i_cfg_data,
    output srr_pkg::t_geom               o_geom
);
    import srr_pkg::*;

    logic [CoordW-1:0] r_region_left;
    logic [CoordW-1:0] r_region_top;
    logic [DimW-1:0]   r_region_columns;
    logic [DimW-1:0]   r_region_rows;
    logic [DimW-1:0]   r_surface_columns;
    logic [DimW-1:0]   r_surface_rows;
    t_geom             r_geom;
    t_geom             n_geom;

    logic [DimW-1:0] rc, rr, sc, sr;
    logic [DimW-1:0] right_raw, bottom_raw, right, bottom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_left     <= '0;
            r_region_top      <= '0;
            r_region_columns  <= '0;
            r_region_rows     <= '0;
            r_surface_columns <= '0;
            r_surface_rows    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_REGION_LEFT:     r_region_left     <= i_cfg_data[CoordW-1:0];
                REG_REGION_TOP:      r_region_top      <= i_cfg_data[CoordW-1:0];
                REG_REGION_COLUMNS:  r_region_columns  <= i_cfg_data;
                REG_REGION_ROWS:     r_region_rows     <= i_cfg_data;
                REG_SURFACE_COLUMNS: r_surface_columns <= i_cfg_data;
                REG_SURFACE_ROWS:    r_surface_rows    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        rc = sat_dim(r_region_columns);
        rr = sat_dim(r_region_rows);
        sc = sat_dim(r_surface_columns);
        sr = sat_dim(r_surface_rows);
        // The left edge plus a saturated width stays below 8192.
        right_raw  = {1'b0, r_region_left} + rc;
        bottom_raw = {1'b0, r_region_top} + rr;
        right  = (right_raw < sc) ? right_raw : sc;
        bottom = (bottom_raw < sr) ? bottom_raw : sr;

        n_geom.surf_cols = sc;
        n_geom.surf_rows = sr;
        n_geom.valid     = (right > {1'b0, r_region_left}) && (bottom > {1'b0, r_region_top});
        n_geom.left      = r_region_left;
        n_geom.top       = r_region_top;
        n_geom.right     = right;
        n_geom.bottom    = bottom;
        n_geom.rows      = bottom - {1'b0, r_region_top};
    end

    always_ff @(posedge i_clk) begin
        r_geom <= n_geom;
    end

    assign o_geom = r_geom;

endmodule

// ===== rtl/srr_mod_unit.sv =====
module srr_mod_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [srr_pkg::OffsetW-1:0]  i_dividend,
    input  logic [srr_pkg::DimW-1:0]     i_divisor,
    input  logic                         i_load,
    input  logic [srr_pkg::OffsetW-1:0]  i_load_val,
    output logic                         o_busy,
    output logic [srr_pkg::OffsetW-1:0]  o_rem
);
    import srr_pkg::*;

    localparam int StepW  = $clog2(OffsetW);
    localparam int TrialW = OffsetW + DimW - 1;

    t_mod_state         r_state;
    t_mod_state         n_state;
    logic [StepW-1:0]   r_step;
    logic [OffsetW-1:0] r_rem;
    logic [OffsetW-1:0] n_rem;
    logic [TrialW-1:0]  trial;
    logic [TrialW-1:0]  rem_ext;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            MOD_IDLE: begin
                if (i_start) n_state = MOD_SETTLE;
            end
            MOD_SETTLE: begin
                if (!i_start) n_state = MOD_RUN;
            end
            MOD_RUN: begin
                if (i_start) begin
                    n_state = MOD_SETTLE;
                end else if (r_step == '0) begin
                    n_state = MOD_IDLE;
                end
            end
            default: n_state = MOD_IDLE;
        endcase
    end

    always_comb begin
        o_busy = (r_state != MOD_IDLE);
        o_rem  = r_rem;
    end

    // Restoring reduction: one shifted copy of the divisor is tried per cycle.
    always_comb begin
        trial   = {{(OffsetW-1){1'b0}}, i_divisor} << r_step;
        rem_ext = {{(DimW-1){1'b0}}, r_rem};
        n_rem   = (rem_ext >= trial) ? (r_rem - trial[OffsetW-1:0]) : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MOD_IDLE;
            r_rem   <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                MOD_IDLE: begin
                    if (i_load) r_rem <= i_load_val;
                end
                MOD_SETTLE: r_rem <= i_dividend;
                MOD_RUN:    r_rem <= n_rem;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == MOD_SETTLE) begin
            r_step <= StepW'(OffsetW - 1);
        end else if (r_state == MOD_RUN) begin
            r_step <= r_step - 1'b1;
        end
    end

    a_rem_never_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == MOD_RUN && !i_start) |=> (r_rem <= $past(r_rem)))
        else $error("offset remainder grew during reduction");

    a_idle_holds_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == MOD_IDLE && !i_load && !i_start) |=> $stable(r_rem))
        else $error("offset changed without a load while idle");

endmodule

// ===== rtl/srr_result_queue.sv =====
module srr_result_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  srr_pkg::t_bundle  i_bundle,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output srr_pkg::t_result  o_result
);
    import srr_pkg::*;

    localparam int Depth = 2;

    t_bundle    r_q [Depth];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic       r_sub;
    t_bundle    head;
    logic       take;
    logic       pop;

    always_comb begin
        head    = r_q[r_rd];
        o_valid = (r_count != '0);
        o_space = (r_count < 2'(Depth));
        take    = o_valid && i_ready;
        pop     = take && (r_sub || !head.two);

        o_result.kind       = head.kind;
        o_result.x          = head.x;
        o_result.y          = r_sub ? head.y1 : head.y0;
        o_result.w          = head.w;
        o_result.h          = r_sub ? head.h1 : head.h0;
        o_result.color      = head.color;
        o_result.in_surface = head.in_surface;
        o_result.in_region  = head.in_region;
        o_result.last       = r_sub || !head.two;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wr] <= i_bundle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= '0;
            r_sub   <= 1'b0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (pop)    r_rd <= ~r_rd;
            r_count <= r_count + {1'b0, i_push} - {1'b0, pop};
            if (take) r_sub <= !pop;
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < 2'(Depth)))
        else $error("result pushed into a full queue");

    a_sub_only_on_pairs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> (o_valid && head.two))
        else $error("second result selected for a single-result item");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import srr_pkg::*;

    localparam int IdleLimit   = 2000;
    localparam int PhaseCount  = 8;
    localparam int PhaseItems  = 125;
    localparam int LongHoldOff = 300;

    typedef struct {
        int unsigned x;
        int unsigned y;
        int unsigned w;
        int unsigned h;
    } area_t;

    // Tracks the scroll offset and register copies and predicts the results of each item.
    class remap_tracker;
        int unsigned left_reg, top_reg, cols_reg, rows_reg, surf_cols, surf_rows;
        int unsigned row_offset;
        t_result     pending_results[$];
        int          errors, points, fills, wraps, fallbacks;

        function void set_reg(logic [2:0] idx, logic [12:0] val);
            case (idx)
                REG_REGION_LEFT:     left_reg  = val[11:0];
                REG_REGION_TOP:      top_reg   = val[11:0];
                REG_REGION_COLUMNS:  cols_reg  = val;
                REG_REGION_ROWS:     rows_reg  = val;
                REG_SURFACE_COLUMNS: surf_cols = val;
                REG_SURFACE_ROWS:    surf_rows = val;
                default: ;
            endcase
        endfunction

        function int unsigned clamp_dim(int unsigned v);
            return (v > MaxDimension) ? MaxDimension : v;
        endfunction

        function area_t overlap(area_t a, area_t b);
            area_t r;
            int unsigned x0, y0, x1, y1;
            r  = '{0, 0, 0, 0};
            x0 = (a.x > b.x) ? a.x : b.x;
            y0 = (a.y > b.y) ? a.y : b.y;
            x1 = (a.x + a.w < b.x + b.w) ? a.x + a.w : b.x + b.w;
            y1 = (a.y + a.h < b.y + b.h) ? a.y + a.h : b.y + b.h;
            if (x1 > x0 && y1 > y0) begin
                r = '{x0, y0, x1 - x0, y1 - y0};
            end
            return r;
        endfunction

        function area_t surface_area();
            area_t s;
            s = '{0, 0, clamp_dim(surf_cols), clamp_dim(surf_rows)};
            return s;
        endfunction

        function area_t region_area();
            area_t r;
            r = '{left_reg, top_reg, clamp_dim(cols_reg), clamp_dim(rows_reg)};
            return overlap(r, surface_area());
        endfunction

        function bit is_empty(area_t r);
            return r.w == 0 || r.h == 0;
        endfunction

        function bit holds(area_t r, int unsigned x, int unsigned y);
            return !is_empty(r) && x >= r.x && y >= r.y && x < r.x + r.w && y < r.y + r.h;
        endfunction

        // The offset is taken modulo the height, so a stale offset still maps sensibly.
        function int unsigned rotate(area_t g, int unsigned y);
            return g.y + ((y - g.y) + row_offset) % g.h;
        endfunction

        function void push(t_kind kind, int unsigned x, int unsigned y, int unsigned w,
                           int unsigned h, logic [31:0] color, bit ins, bit inr, bit last);
            t_result r;
            r.kind       = kind;
            r.x          = x[11:0];
            r.y          = y[11:0];
            r.w          = w[12:0];
            r.h          = h[12:0];
            r.color      = color;
            r.in_surface = ins;
            r.in_region  = inr;
            r.last       = last;
            pending_results.push_back(r);
        endfunction

        function void predict_command(t_mode mode, logic [12:0] distance, logic [11:0] px,
                                      logic [11:0] py, logic [12:0] sw, logic [12:0] sh,
                                      logic [31:0] color);
            area_t       g, r, ov, req;
            int unsigned top, bottom, first;
            bit          ins, inr;
            g = region_area();
            case (mode)
                MODE_SCROLL: begin
                    if (!is_empty(g) && distance != 0) begin
                        row_offset = (distance >= g.h) ? 0 : (row_offset + distance) % g.h;
                    end
                end
                MODE_RESET: row_offset = 0;
                MODE_MAP: begin
                    ins = holds(surface_area(), px, py);
                    inr = holds(g, px, py);
                    push(KIND_POINT, px, inr ? rotate(g, py) : py, 0, 0, 0, ins, inr, 1'b1);
                    points++;
                end
                default: begin
                    req = '{px, py, sw, sh};
                    r   = overlap(req, surface_area());
                    if (!is_empty(r)) begin
                        ov = overlap(r, g);
                        fills++;
                        if (row_offset == 0 || is_empty(ov)) begin
                            push(KIND_FILL, r.x, r.y, r.w, r.h, color, 0, 0, 1'b1);
                        end else if (ov == r) begin
                            top    = rotate(g, r.y);
                            bottom = g.y + g.h;
                            if (top + r.h <= bottom) begin
                                push(KIND_FILL, r.x, top, r.w, r.h, color, 0, 0, 1'b1);
                            end else begin
                                first = bottom - top;
                                push(KIND_FILL, r.x, top, r.w, first, color, 0, 0, 1'b0);
                                push(KIND_FILL, r.x, g.y, r.w, r.h - first, color, 0, 0, 1'b1);
                                wraps++;
                            end
                        end else begin
                            push(KIND_FALLBACK, r.x, r.y, r.w, r.h, color, 0, 0, 1'b1);
                            fallbacks++;
                        end
                    end
                end
            endcase
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] seen);
            errors++;
            if (errors <= 30) begin
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, seen);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual %p", $time, got);
                return;
            end
            want = pending_results.pop_front();
            if (got.kind !== want.kind)             report("kind", want.kind, got.kind);
            if (got.x !== want.x)                   report("out_x", want.x, got.x);
            if (got.y !== want.y)                   report("out_y", want.y, got.y);
            if (got.w !== want.w)                   report("out_w", want.w, got.w);
            if (got.h !== want.h)                   report("out_h", want.h, got.h);
            if (got.color !== want.color)           report("out_color", want.color, got.color);
            if (got.in_surface !== want.in_surface) report("inside_surface", want.in_surface,
                                                           got.in_surface);
            if (got.in_region !== want.in_region)   report("inside_region", want.in_region,
                                                           got.in_region);
            if (got.last !== want.last)             report("last", want.last, got.last);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [2:0]  i_cfg_index   = REG_REGION_LEFT;
    logic [12:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = MODE_SCROLL;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    remap_tracker tracker = new;
    bit           burst_phase   = 1'b0;
    bit           hold_off_req  = 1'b0;
    int           items_sent    = 0;
    int           settings_used = 0;

    scroll_region_row_remapper i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned fit12(int v);
        return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
    endfunction

    task automatic send_item(t_mode mode, logic [12:0] distance, logic [11:0] px,
                             logic [11:0] py, logic [12:0] sw, logic [12:0] sh,
                             logic [31:0] color);
        int gap;
        gap = burst_phase ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {1'b0, color, sh, sw, py, px, distance};
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.predict_command(mode, distance, px, py, sw, sh, color);
        items_sent++;
    endtask

    // Lets the block finish all work so the registers can be rewritten safely.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [12:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        tracker.set_reg(idx, val);
    endtask

    task automatic write_setting(logic [12:0] left, logic [12:0] top, logic [12:0] cols,
                                 logic [12:0] rows, logic [12:0] scols, logic [12:0] srows);
        cfg_write(REG_REGION_LEFT, left);
        cfg_write(REG_REGION_TOP, top);
        cfg_write(REG_REGION_COLUMNS, cols);
        cfg_write(REG_REGION_ROWS, rows);
        cfg_write(REG_SURFACE_COLUMNS, scols);
        cfg_write(REG_SURFACE_ROWS, srows);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic int unsigned pick_dim();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 5)  return 0;
        if (p < 15) return $urandom_range(4097, 8191);
        if (p < 22) return 4096;
        if (p < 60) return $urandom_range(1, 256);
        return $urandom_range(1, 4096);
    endfunction

    task automatic write_random_setting();
        int unsigned sc, sr, l, t, c, r;
        sc = pick_dim();
        sr = pick_dim();
        l  = ($urandom_range(0, 9) < 8) ? $urandom_range(0, fit12(tracker.clamp_dim(sc)))
                                         : $urandom_range(0, 8191);
        t  = ($urandom_range(0, 9) < 8) ? $urandom_range(0, fit12(tracker.clamp_dim(sr)))
                                         : $urandom_range(0, 8191);
        c  = ($urandom_range(0, 9) == 0) ? pick_dim() : $urandom_range(1, 512);
        r  = ($urandom_range(0, 9) == 0) ? pick_dim() : $urandom_range(1, 512);
        write_setting(l, t, c, r, sc, sr);
    endtask

    task automatic send_random_item();
        area_t       g, s;
        int unsigned pick;
        int          xi, yi, wi, hi, di;
        t_mode       mode;
        g    = tracker.region_area();
        s    = tracker.surface_area();
        pick = $urandom_range(0, 99);
        mode = (pick < 25) ? MODE_SCROLL : (pick < 29) ? MODE_RESET :
               (pick < 60) ? MODE_MAP : MODE_FILL;
        xi   = $urandom_range(0, 4095);
        yi   = $urandom_range(0, 4095);
        wi   = $urandom_range(0, 8191);
        hi   = $urandom_range(0, 8191);
        di   = $urandom_range(0, 8191);
        pick = $urandom_range(0, 99);
        case (mode)
            MODE_SCROLL: begin
                if (pick < 75 && g.h > 0) di = $urandom_range(1, g.h);
                else if (pick < 85) di = 0;
            end
            MODE_MAP: begin
                if (pick < 55 && g.w > 0) begin
                    xi = g.x + $urandom_range(0, g.w - 1);
                    yi = g.y + $urandom_range(0, g.h - 1);
                end else if (pick < 85) begin
                    xi = $urandom_range(0, s.w + 2);
                    yi = $urandom_range(0, s.h + 2);
                end
            end
            MODE_FILL: begin
                if (pick < 45 && g.w > 0) begin
                    // Wholly inside the region, so it rotates and may wrap.
                    xi = g.x + $urandom_range(0, g.w - 1);
                    yi = g.y + $urandom_range(0, g.h - 1);
                    wi = $urandom_range(1, g.x + g.w - xi);
                    hi = $urandom_range(1, g.y + g.h - yi);
                end else if (pick < 70 && g.w > 0) begin
                    xi = g.x + int'($urandom_range(0, g.w)) - int'($urandom_range(0, 16));
                    yi = g.y + int'($urandom_range(0, g.h)) - int'($urandom_range(0, 16));
                    wi = $urandom_range(1, g.w + 32);
                    hi = $urandom_range(1, g.h + 32);
                end else if (pick < 90) begin
                    xi = $urandom_range(0, s.w);
                    yi = $urandom_range(0, s.h);
                    wi = $urandom_range(0, s.w + 8);
                    hi = $urandom_range(0, s.h + 8);
                end
            end
            default: ;
        endcase
        send_item(mode, di, fit12(xi), fit12(yi), wi, hi, $urandom);
    endtask

    // Result side: random stalls, one long hold-off on request.
    initial begin
        int      stall;
        t_result got;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                stall        = LongHoldOff;
                hold_off_req = 1'b0;
            end else begin
                stall = burst_phase ? 0 : $urandom_range(0, 10);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got.kind       = t_kind'(m_axis_tuser);
            got.x          = m_axis_tdata[11:0];
            got.y          = m_axis_tdata[23:12];
            got.w          = m_axis_tdata[36:24];
            got.h          = m_axis_tdata[49:37];
            got.color      = m_axis_tdata[81:50];
            got.in_surface = m_axis_tdata[82];
            got.in_region  = m_axis_tdata[83];
            got.last       = m_axis_tlast;
            tracker.check_result(got);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IdleLimit) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t: no item moved for %0d cycles", $time, IdleLimit);
        $display("FAILURE");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Registers still at their reset values: no surface and no region.
        send_item(MODE_MAP, 0, 12'd5, 12'd5, 0, 0, 0);
        send_item(MODE_SCROLL, 13'd7, 0, 0, 0, 0, 0);
        drain();

        // Region spans columns 100..299 and rows 50..149 of a 640 by 480 surface.
        write_setting(100, 50, 200, 100, 640, 480);
        send_item(MODE_MAP, 0, 12'd0, 12'd0, 0, 0, 0);
        send_item(MODE_MAP, 0, 12'd4095, 12'd4095, 0, 0, 0);
        send_item(MODE_FILL, 0, 12'd0, 12'd0, 13'd0, 13'd0, 32'h0);
        send_item(MODE_FILL, 0, 12'd4095, 12'd4095, 13'h1FFF, 13'h1FFF, 32'hFFFF_FFFF);
        send_item(MODE_FILL, 0, 12'd0, 12'd0, 13'h1FFF, 13'h1FFF, 32'h1234_5678);
        send_item(MODE_SCROLL, 13'd0, 0, 0, 0, 0, 0);
        send_item(MODE_SCROLL, 13'd30, 0, 0, 0, 0, 0);
        send_item(MODE_MAP, 0, 12'd150, 12'd60, 0, 0, 0);
        send_item(MODE_MAP, 0, 12'd99, 12'd60, 0, 0, 0);
        send_item(MODE_MAP, 0, 12'd299, 12'd149, 0, 0, 0);
        send_item(MODE_MAP, 0, 12'd300, 12'd150, 0, 0, 0);
        send_item(MODE_FILL, 0, 12'd120, 12'd55, 13'd20, 13'd10, 32'hA5A5_0001);
        send_item(MODE_FILL, 0, 12'd120, 12'd110, 13'd20, 13'd15, 32'h5A5A_0002);
        send_item(MODE_FILL, 0, 12'd90, 12'd60, 13'd30, 13'd10, 32'h0000_0003);
        send_item(MODE_FILL, 0, 12'd400, 12'd300, 13'd50, 13'd50, 32'h8000_0004);
        send_item(MODE_FILL, 0, 12'd100, 12'd50, 13'd200, 13'd100, 32'h7FFF_FFFF);
        send_item(MODE_SCROLL, 13'h1FFF, 0, 0, 0, 0, 0);
        send_item(MODE_FILL, 0, 12'd90, 12'd60, 13'd30, 13'd10, 32'h0000_0005);
        send_item(MODE_SCROLL, 13'd99, 0, 0, 0, 0, 0);
        send_item(MODE_SCROLL, 13'd5, 0, 0, 0, 0, 0);
        send_item(MODE_MAP, 0, 12'd200, 12'd149, 0, 0, 0);
        send_item(MODE_RESET, 0, 0, 0, 0, 0, 0);
        send_item(MODE_MAP, 0, 12'd200, 12'd149, 0, 0, 0);
        drain();

        // The row offset is kept across settings, so new heights see stale offsets.
        for (int phase = 0; phase < PhaseCount; phase++) begin
            case (phase)
                0: write_setting(0, 0, 4096, 4096, 4096, 4096);
                1: write_setting(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF);
                2: write_setting(250, 150, 400, 400, 300, 200);
                3: write_setting(10, 10, 0, 64, 128, 128);
                default: write_random_setting();
            endcase
            burst_phase  = (phase % 3 == 1);
            hold_off_req = (phase == 2);
            for (int n = 0; n < PhaseItems; n++) begin
                if (n % 40 == 39 && phase >= 4) begin
                    drain();
                    write_random_setting();
                end
                send_random_item();
            end
            drain();
        end
        burst_phase = 1'b0;
        repeat (10) @(posedge i_clk);

        $display("Sent %0d items over %0d register settings.", items_sent, settings_used);
        $display("Predicted %0d points, %0d fills, %0d of them wrapped, %0d fallbacks.",
                 tracker.points, tracker.fills, tracker.wraps, tracker.fallbacks);
        if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/srr_pkg.sv
rtl/srr_cfg_geom.sv
rtl/srr_mod_unit.sv
rtl/srr_result_queue.sv
rtl/scroll_region_row_remapper.sv
bench/testbench.sv
